FILE: hdl/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types, constants and tables for the day serial to date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  localparam int unsigned SERIAL_W = 22;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;

  localparam logic [SERIAL_W-1:0] SWITCH_SERIAL = 22'd639799;
  localparam logic [SERIAL_W-1:0] LAST_SERIAL   = 22'd3652061;
  localparam logic [SERIAL_W-1:0] SHIFT_JULIAN  = 22'd305;
  localparam logic [SERIAL_W-1:0] SHIFT_GREG    = 22'd303;

  localparam logic [17:0] DAYS_4Y     = 18'd1461;
  localparam logic [17:0] DAYS_400Y   = 18'd146097;
  localparam logic [11:0] RECIP_4Y    = 12'd2870;
  localparam logic [11:0] RECIP_400Y  = 12'd28;
  localparam int unsigned RECIP_SHIFT = 22;

  localparam logic [17:0] DAYS_4Y_LESS = 18'd1460;
  localparam logic [7:0]  RECIP_1460   = 8'd179;
  localparam logic [17:0] DAYS_100Y    = 18'd36524;
  localparam logic [17:0] DAYS_400Y_LESS = 18'd146096;
  localparam logic [9:0]  RECIP_365    = 10'd718;
  localparam int unsigned MID_SHIFT    = 18;

  localparam logic [3:0]  RECIP_153    = 4'd13;
  localparam int unsigned SMALL_SHIFT  = 11;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                ok;
    logic                greg;
    logic [SERIAL_W-1:0] z;
  } item_t;

  // First day index of each month within a year that starts on March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/day_serial_to_calendar_date.sv
// ----------------------------------------------------------------------------
// day_serial_to_calendar_date
// Converts a day serial, where 0001-01-01 is 1, into year, month and day,
// with the Julian rule before 14 Sep 1752 and the Gregorian rule after.
// ----------------------------------------------------------------------------
// A serial is taken at any edge where start is high and busy is low, one
// every cycle. Its date appears on the result ports for one cycle with done
// high, after the queue stage, the twelve-stage division pipeline and the
// output register. Results cannot be held off, so the back end never stops
// and busy stays low in practice.
// Out-of-range serials give in_range low and zero date fields.
`default_nettype none

module day_serial_to_calendar_date (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [dsc_pkg::SERIAL_W-1:0] day_serial,
  output logic                              done,
  output logic [dsc_pkg::YEAR_W-1:0]        year_number,
  output logic [dsc_pkg::MONTH_W-1:0]       month_number,
  output logic [dsc_pkg::DAY_W-1:0]         day_of_month,
  output logic                              in_range
);
  import dsc_pkg::*;

  logic  push;
  item_t push_item;
  logic  full;
  logic  not_empty;
  item_t head;

  assign busy = full;

  dsc_front u_front (
    .start      (start),
    .full       (full),
    .day_serial (day_serial),
    .push       (push),
    .item       (push_item)
  );

  dsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (not_empty),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  dsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (not_empty),
    .in_item      (head),
    .done         (done),
    .year_number  (year_number),
    .month_number (month_number),
    .day_of_month (day_of_month),
    .in_range     (in_range)
  );

endmodule

`default_nettype wire

FILE: hdl/dsc_front.sv
// ----------------------------------------------------------------------------
// dsc_front
// Accepts serials, checks the range, picks the calendar rule and rebases the
// serial to a day count from March 1 of year zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_front (
  input  wire logic                         start,
  input  wire logic                         full,
  input  wire logic [dsc_pkg::SERIAL_W-1:0] day_serial,
  output logic                              push,
  output dsc_pkg::item_t                    item
);
  import dsc_pkg::*;

  logic ok;
  logic greg;

  assign ok   = (day_serial != '0) && (day_serial <= LAST_SERIAL);
  assign greg = (day_serial >= SWITCH_SERIAL);
  assign push = start && !full;

  always_comb begin
    item.ok   = ok;
    item.greg = greg;
    if (!ok) begin
      item.z = '0;
    end else if (greg) begin
      item.z = day_serial + SHIFT_GREG;
    end else begin
      item.z = day_serial + SHIFT_JULIAN;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dsc_queue.sv
// ----------------------------------------------------------------------------
// dsc_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire dsc_pkg::item_t push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output dsc_pkg::item_t      head
);
  import dsc_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dsc_back.sv
// ----------------------------------------------------------------------------
// dsc_back
// Pipeline that splits the day count into cycle, year, month and day by
// reciprocal multiplication with one correction step per division.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire dsc_pkg::item_t              in_item,
  output logic                             done,
  output logic [dsc_pkg::YEAR_W-1:0]       year_number,
  output logic [dsc_pkg::MONTH_W-1:0]      month_number,
  output logic [dsc_pkg::DAY_W-1:0]        day_of_month,
  output logic                             in_range
);
  import dsc_pkg::*;

  localparam int unsigned STAGES = 12;

  typedef struct packed {
    logic                ok;
    logic                greg;
    logic [SERIAL_W-1:0] z;
    logic [8:0]          q1;
    logic [18:0]         r1;
    logic [17:0]         t;
    logic [7:0]          a;
    logic [2:0]          c36;
    logic                e;
    logic [11:0]         ra;
    logic [17:0]         n;
    logic [8:0]          yoe;
    logic [9:0]          ry;
    logic [8:0]          doy;
    logic [10:0]         x;
    logic [3:0]          mp;
  } pipe_t;

  pipe_t             st [STAGES];
  pipe_t             nx [STAGES];
  logic [STAGES-1:0] vld;

  logic [17:0] dsel1;
  logic [17:0] dsel2;
  logic [33:0] prod_q;
  logic [26:0] prod_qd;
  logic [25:0] prod_a;
  logic [18:0] prod_ad;
  logic [27:0] prod_y;
  logic [17:0] prod_yd5;
  logic [17:0] prod_yd9;
  logic [1:0]  c100;
  logic [14:0] prod_m;
  logic [10:0] prod_md;
  logic [3:0]  mon;
  logic [13:0] year_base;

  assign dsel1 = st[0].greg ? DAYS_400Y : DAYS_4Y;
  assign dsel2 = st[1].greg ? DAYS_400Y : DAYS_4Y;

  assign prod_q   = in_item.z * (in_item.greg ? RECIP_400Y : RECIP_4Y);
  assign prod_qd  = st[0].q1 * dsel1;
  assign prod_a   = st[2].t * RECIP_1460;
  assign prod_ad  = st[3].a * 11'(DAYS_4Y_LESS);
  assign prod_y   = st[5].n * RECIP_365;
  assign prod_yd5 = 18'(st[6].yoe) * 18'd365;
  assign prod_yd9 = 18'(st[8].yoe) * 18'd365;
  assign c100     = 2'(st[8].yoe >= 9'd100) + 2'(st[8].yoe >= 9'd200)
                  + 2'(st[8].yoe >= 9'd300);
  assign prod_m   = (11'(st[9].doy) * 11'd5 + 11'd2) * RECIP_153;
  assign prod_md  = 11'(st[10].mp) * 11'd153;

  always_comb begin
    nx[0]    = '0;
    nx[0].ok   = in_item.ok;
    nx[0].greg = in_item.greg;
    nx[0].z    = in_item.z;
    nx[0].q1   = 9'(prod_q >> RECIP_SHIFT);

    nx[1]    = st[0];
    nx[1].r1 = 19'(st[0].z - 22'(prod_qd));

    nx[2] = st[1];
    if (st[1].r1 >= 19'(dsel2)) begin
      nx[2].q1 = st[1].q1 + 9'd1;
      nx[2].t  = 18'(st[1].r1 - 19'(dsel2));
    end else begin
      nx[2].t  = 18'(st[1].r1);
    end

    nx[3]     = st[2];
    nx[3].a   = 8'(prod_a >> MID_SHIFT);
    nx[3].c36 = 3'(st[2].t >= DAYS_100Y) + 3'(st[2].t >= 18'd73048)
              + 3'(st[2].t >= 18'd109572) + 3'(st[2].t >= DAYS_400Y_LESS);
    nx[3].e   = (st[2].t == DAYS_400Y_LESS);

    nx[4]    = st[3];
    nx[4].ra = 12'(st[3].t - 18'(prod_ad));

    nx[5]   = st[4];
    nx[5].n = st[4].t + 18'(st[4].c36) - 18'(st[4].a)
            - 18'(st[4].ra >= 12'(DAYS_4Y_LESS)) - 18'(st[4].e);

    nx[6]     = st[5];
    nx[6].yoe = 9'(prod_y >> MID_SHIFT);

    nx[7]    = st[6];
    nx[7].ry = 10'(st[6].n - prod_yd5);

    nx[8] = st[7];
    nx[8].yoe = st[7].yoe + 9'(st[7].ry >= 10'd365);

    nx[9]     = st[8];
    nx[9].doy = 9'(st[8].t - (prod_yd9 + 18'(st[8].yoe >> 2) - 18'(c100)));

    nx[10]    = st[9];
    nx[10].x  = 11'(st[9].doy) * 11'd5 + 11'd2;
    nx[10].mp = 4'(prod_m >> SMALL_SHIFT);

    nx[11]    = st[10];
    nx[11].mp = st[10].mp + 4'((st[10].x - prod_md) >= 11'd153);
  end

  assign mon       = (st[11].mp < 4'd10) ? st[11].mp + 4'd3 : st[11].mp - 4'd9;
  assign year_base = st[11].greg ? 14'(st[11].q1) * 14'd400 : 14'({st[11].q1, 2'b00});

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      st[k] <= nx[k];
    end
    if (st[11].ok) begin
      year_number  <= year_base + 14'(st[11].yoe) + 14'(mon <= 4'd2);
      month_number <= mon;
      day_of_month <= 5'(st[11].doy - month_start(st[11].mp) + 9'd1);
      in_range     <= 1'b1;
    end else begin
      year_number  <= '0;
      month_number <= '0;
      day_of_month <= '0;
      in_range     <= 1'b0;
    end
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[STAGES-2:0], in_valid};
      done <= vld[STAGES-1];
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/day_serial_to_calendar_date_test.sv
// ----------------------------------------------------------------------------
// day_serial_to_calendar_date_test
// Self-checking regression for the day serial to calendar date converter.
// Serials go in bursts with random gaps, but back to back in the last test.
// Directed dates cover the range ends, leap days and the 1752 switch, then
// random serials follow. Each date that comes out is compared field by field
// with a date computed in the bench from the accepted serial.
// ----------------------------------------------------------------------------

module day_serial_to_calendar_date_test;

  timeunit 1ns;
  timeprecision 1ps;

  import dsc_pkg::*;

  localparam int unsigned MARCH_OFFSET  = 305;
  localparam int unsigned GREG_ORD_LAG  = 2;
  localparam int unsigned JULIAN_CYCLE  = 1461;
  localparam int unsigned GREG_CYCLE    = 146097;
  localparam int unsigned PIPE_LATENCY  = 14;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam logic [SERIAL_W-1:0] MAX_SERIAL = '1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               ok;
  } calendar_date_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [SERIAL_W-1:0] day_serial = '0;
  logic                busy;
  logic                done;
  logic [YEAR_W-1:0]   year_number;
  logic [MONTH_W-1:0]  month_number;
  logic [DAY_W-1:0]    day_of_month;
  logic                in_range;

  calendar_date_t pending_dates[$];
  int unsigned    errors = 0;
  int unsigned    serials_sent = 0;
  int unsigned    dates_checked = 0;
  int unsigned    dates_in_range = 0;
  int unsigned    burst_left = 0;
  bit             gaps_on = 1'b1;

  day_serial_to_calendar_date u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .day_serial   (day_serial),
    .done         (done),
    .year_number  (year_number),
    .month_number (month_number),
    .day_of_month (day_of_month),
    .in_range     (in_range)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic calendar_date_t serial_to_date(input logic [SERIAL_W-1:0] serial);
    calendar_date_t d;
    int unsigned s, z, cyc, doc, yoc, doy, mp, mon, dom, base;
    d = '0;
    s = serial;
    if (s >= 1 && s <= LAST_SERIAL) begin
      if (s >= SWITCH_SERIAL) begin
        z    = s - GREG_ORD_LAG + MARCH_OFFSET;
        cyc  = z / GREG_CYCLE;
        doc  = z - cyc * GREG_CYCLE;
        yoc  = (doc - doc / 1460 + doc / 36524 - doc / 146096) / 365;
        doy  = doc - (365 * yoc + yoc / 4 - yoc / 100);
        base = cyc * 400;
      end else begin
        z    = s + MARCH_OFFSET;
        cyc  = z / JULIAN_CYCLE;
        doc  = z - cyc * JULIAN_CYCLE;
        yoc  = (doc - doc / 1460) / 365;
        doy  = doc - 365 * yoc;
        base = cyc * 4;
      end
      mp  = (5 * doy + 2) / 153;
      dom = doy - (153 * mp + 2) / 5 + 1;
      mon = (mp < 10) ? mp + 3 : mp - 9;
      d.year  = YEAR_W'(base + yoc + ((mon <= 2) ? 1 : 0));
      d.month = MONTH_W'(mon);
      d.day   = DAY_W'(dom);
      d.ok    = 1'b1;
    end
    return d;
  endfunction

  always @(posedge clk) begin : date_check
    calendar_date_t want;
    if (!rst) begin
      if (start && !busy) begin
        pending_dates.push_back(serial_to_date(day_serial));
      end
      if (done) begin
        if (pending_dates.size() == 0) begin
          $error("unexpected date beat: year %0d month %0d day %0d in_range %0b",
                 year_number, month_number, day_of_month, in_range);
          errors++;
        end else begin
          want = pending_dates.pop_front();
          dates_checked++;
          if (in_range) dates_in_range++;
          if (year_number !== want.year) begin
            $error("year_number: expected %0d, actual %0d", want.year, year_number);
            errors++;
          end
          if (month_number !== want.month) begin
            $error("month_number: expected %0d, actual %0d", want.month, month_number);
            errors++;
          end
          if (day_of_month !== want.day) begin
            $error("day_of_month: expected %0d, actual %0d", want.day, day_of_month);
            errors++;
          end
          if (in_range !== want.ok) begin
            $error("in_range: expected %0b, actual %0b", want.ok, in_range);
            errors++;
          end
        end
      end
    end
  end

  // Called on a rising edge; returns on the edge that accepts the beat.
  task automatic send_serial(input logic [SERIAL_W-1:0] serial);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        if ($urandom_range(3, 0) != 0) begin
          gap = $urandom_range(20, 1);
          start      <= 1'b0;
          day_serial <= SERIAL_W'($urandom);
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    start      <= 1'b1;
    day_serial <= serial;
    do @(posedge clk); while (busy);
    serials_sent++;
  endtask

  task automatic test_directed();
    logic [SERIAL_W-1:0] serials[$];
    serials = {22'd0, 22'd1, 22'd2, 22'd59, 22'd60, 22'd365, 22'd366,
               22'd1155, 22'd1156, 22'd1460, 22'd1461,
               22'd639797, 22'd639798, 22'd639799, 22'd639800,
               22'd657132, 22'd657133, 22'd730181,
               22'd3652060, 22'd3652061, 22'd3652062,
               22'h2AAAAA, 22'h155555, MAX_SERIAL};
    foreach (serials[i]) send_serial(serials[i]);
  endtask

  task automatic test_random_in_range(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(3, 0) == 0) begin
        send_serial(SERIAL_W'($urandom_range(SWITCH_SERIAL + 400, SWITCH_SERIAL - 400)));
      end else begin
        send_serial(SERIAL_W'($urandom_range(LAST_SERIAL, 1)));
      end
    end
  endtask

  task automatic test_random_full(input int unsigned count);
    repeat (count) send_serial(SERIAL_W'($urandom));
  endtask

  task automatic test_back_to_back(input int unsigned count);
    int unsigned first;
    gaps_on = 1'b0;
    first = $urandom_range(LAST_SERIAL - count, 1);
    for (int unsigned i = 0; i < count; i++) send_serial(SERIAL_W'(first + i));
    for (int unsigned i = 0; i < 40; i++) send_serial(SERIAL_W'(657100 + i));
    for (int unsigned i = 0; i < 20; i++) send_serial(SERIAL_W'(SWITCH_SERIAL - 10 + i));
    gaps_on = 1'b1;
  endtask

  initial begin : sequencer
    int unsigned waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_in_range(260);
    test_random_full(120);
    test_back_to_back(60);
    start <= 1'b0;
    waited = 0;
    while (pending_dates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (pending_dates.size() != 0) begin
      $error("%0d dates never arrived", pending_dates.size());
      errors++;
    end
    $display("Sent %0d serials and checked %0d dates, %0d of them in range.",
             serials_sent, dates_checked, dates_in_range);
    $display("Covered range ends, leap days, the 1752 switch and random serials.");
    if (errors == 0) begin
      $display("day_serial_to_calendar_date regression: pass");
    end else begin
      $display("day_serial_to_calendar_date regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("day_serial_to_calendar_date regression: fail");
    $finish;
  end

endmodule
